FILE: sv/tmfc_pkg.sv
// ----------------------------------------------------------------------------
// tmfc_pkg
// Shared widths, register indexes and lane result types for the touch
// median filter and calibration block.
// ----------------------------------------------------------------------------
package tmfc_pkg;

  // raw conversion width and rail value
  localparam int RAW_W = 12;
  localparam logic [RAW_W-1:0] RAW_MAX = '1;

  // samples per axis in one burst, and the sorted positions we look at
  localparam int SAMPLES_PER_AXIS = 5;
  localparam int MID_IDX = SAMPLES_PER_AXIS / 2;
  localparam int QLO_IDX = SAMPLES_PER_AXIS / 4;
  localparam int QHI_IDX = SAMPLES_PER_AXIS - 1 - SAMPLES_PER_AXIS / 4;

  // one transposition pass per sample plus the check stage
  localparam int SORT_STAGES = SAMPLES_PER_AXIS + 1;

  // scaled numerator: raw span times screen extent minus one (both 12 bits)
  localparam int NUM_W = 2 * RAW_W;

  // internal coordinate width (screen extent up to 4096) and port width
  localparam int COORD_W = 12;
  localparam int SCREEN_OUT_W = 9;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_X_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_X_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_Y_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_Y_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_Y     = 3'd7;

  // one burst of samples for one axis
  typedef logic [SAMPLES_PER_AXIS-1:0][RAW_W-1:0] sample_vec_t;

  // what one axis lane reports
  typedef struct packed {
    logic [RAW_W-1:0] median;
    logic             ok;
  } axis_res_t;

  // side data carried next to the calibration lanes
  typedef struct packed {
    logic [RAW_W-1:0] median_x;
    logic [RAW_W-1:0] median_y;
    logic             touch_valid;
  } out_meta_t;

endpackage

FILE: sv/tmfc_sort_lane.sv
// ----------------------------------------------------------------------------
// tmfc_sort_lane
// One axis lane: odd-even transposition sort, one pass per stage, then a
// check stage that picks the median and tests spread and rails.
// ----------------------------------------------------------------------------
module tmfc_sort_lane (
  input  logic                                 clk,
  input  logic [tmfc_pkg::SORT_STAGES-1:0]     en,
  input  tmfc_pkg::sample_vec_t                samples,
  input  logic [tmfc_pkg::RAW_W-1:0]           spread_limit,
  output tmfc_pkg::axis_res_t                  res
);

  localparam int S = tmfc_pkg::SAMPLES_PER_AXIS;

  tmfc_pkg::sample_vec_t pass_nxt [S];
  tmfc_pkg::sample_vec_t pass_r   [S];
  tmfc_pkg::axis_res_t   res_nxt;
  tmfc_pkg::axis_res_t   res_r;

  // transposition passes, even pairs on even passes and odd pairs on odd
  for (genvar p = 0; p < S; p++) begin : g_pass
    always_comb begin
      tmfc_pkg::sample_vec_t prev;
      if (p == 0) begin
        prev = samples;
      end else begin
        prev = pass_r[(p == 0) ? 0 : p-1];
      end
      pass_nxt[p] = prev;
      for (int i = 0; i < S-1; i++) begin
        if ((i % 2) == (p % 2) && prev[i+1] < prev[i]) begin
          pass_nxt[p][i]   = prev[i+1];
          pass_nxt[p][i+1] = prev[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[p]) begin
        pass_r[p] <= pass_nxt[p];
      end
    end
  end

  // median, quartile spread and rail test on the sorted burst
  always_comb begin
    logic [tmfc_pkg::RAW_W-1:0] spread;
    spread         = pass_r[S-1][tmfc_pkg::QHI_IDX] - pass_r[S-1][tmfc_pkg::QLO_IDX];
    res_nxt.median = pass_r[S-1][tmfc_pkg::MID_IDX];
    res_nxt.ok     = (spread <= spread_limit) &&
                     (res_nxt.median != '0) &&
                     (res_nxt.median != tmfc_pkg::RAW_MAX);
  end

  always_ff @(posedge clk) begin
    if (en[S]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: sv/tmfc_map_lane.sv
// ----------------------------------------------------------------------------
// tmfc_map_lane
// One screen-axis lane: offset, scale by extent minus one, pipelined
// restoring divide by the calibration span, clamp and mirror.
// ----------------------------------------------------------------------------
module tmfc_map_lane #(
  parameter int EXTENT = 320,
  parameter int QW     = 9
) (
  input  logic                          clk,
  input  logic [QW+3:0]                 en,
  input  logic [tmfc_pkg::RAW_W-1:0]    raw,
  input  logic [tmfc_pkg::RAW_W-1:0]    cal_low,
  input  logic [tmfc_pkg::RAW_W-1:0]    cal_high,
  input  logic                          mirror,
  output logic [tmfc_pkg::COORD_W-1:0]  coord
);

  localparam int RAW_W = tmfc_pkg::RAW_W;
  localparam int NUM_W = tmfc_pkg::NUM_W;
  localparam int CW    = tmfc_pkg::COORD_W;
  localparam int RW    = NUM_W + 1;
  localparam logic [CW-1:0] EXT_M1 = CW'(EXTENT - 1);

  // offset stage
  logic signed [RAW_W:0] diff_r, den_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      diff_r <= $signed({1'b0, raw}) - $signed({1'b0, cal_low});
      den_r  <= $signed({1'b0, cal_high}) - $signed({1'b0, cal_low});
    end
  end

  // scale stage: magnitudes, and force zero on empty span or negative quotient
  logic [RAW_W:0]   diff_mag, den_mag;
  logic [NUM_W-1:0] num_nxt;
  logic [NUM_W-1:0] num_r;
  logic [RAW_W-1:0] bmag_r;
  logic             frc_r;

  assign diff_mag = diff_r[RAW_W] ? (RAW_W+1)'(0) - diff_r : diff_r;
  assign den_mag  = den_r[RAW_W]  ? (RAW_W+1)'(0) - den_r  : den_r;
  assign num_nxt  = NUM_W'(diff_mag[RAW_W-1:0]) * NUM_W'(EXTENT - 1);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num_r  <= num_nxt;
      bmag_r <= den_mag[RAW_W-1:0];
      frc_r  <= (den_r == '0) || (diff_r[RAW_W] != den_r[RAW_W]);
    end
  end

  // overflow stage: quotient would not fit in QW bits
  logic [RW-1:0]    rem0_r;
  logic [RAW_W-1:0] b0_r;
  logic             frc0_r, ovf0_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rem0_r <= RW'(num_r);
      b0_r   <= bmag_r;
      frc0_r <= frc_r;
      ovf0_r <= RW'(num_r) >= (RW'(bmag_r) << QW);
    end
  end

  // restoring divide, one quotient bit per stage from the top
  logic [RW-1:0]    rem_r [QW];
  logic [QW-1:0]    q_r   [QW];
  logic [RAW_W-1:0] b_r   [QW];
  logic             frc_d [QW];
  logic             ovf_d [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic [RW-1:0]    rem_in, trial;
    logic [QW-1:0]    q_in;
    logic [RAW_W-1:0] b_in;
    logic             frc_in, ovf_in;

    if (j == 0) begin : g_first
      assign rem_in = rem0_r;
      assign q_in   = '0;
      assign b_in   = b0_r;
      assign frc_in = frc0_r;
      assign ovf_in = ovf0_r;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign b_in   = b_r[j-1];
      assign frc_in = frc_d[j-1];
      assign ovf_in = ovf_d[j-1];
    end

    assign trial = RW'(b_in) << K;

    always_ff @(posedge clk) begin
      if (en[3+j]) begin
        if (rem_in >= trial) begin
          rem_r[j]    <= rem_in - trial;
          q_r[j]      <= q_in | (QW'(1) << K);
        end else begin
          rem_r[j]    <= rem_in;
          q_r[j]      <= q_in;
        end
        b_r[j]   <= b_in;
        frc_d[j] <= frc_in;
        ovf_d[j] <= ovf_in;
      end
    end
  end

  // clamp to the screen and mirror
  logic [CW-1:0] qz, clamped, coord_nxt, coord_r;

  always_comb begin
    qz = CW'(q_r[QW-1]);
    if (frc_d[QW-1]) begin
      clamped = '0;
    end else if (ovf_d[QW-1] || qz > EXT_M1) begin
      clamped = EXT_M1;
    end else begin
      clamped = qz;
    end
    coord_nxt = mirror ? EXT_M1 - clamped : clamped;
  end

  always_ff @(posedge clk) begin
    if (en[QW+3]) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

FILE: sv/touch_median_filter_calibrate.sv
// ----------------------------------------------------------------------------
// touch_median_filter_calibrate
// Median-of-five filter with spread and rail rejection for a resistive touch
// panel, followed by axis swap, linear calibration, clamp and mirror.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   in_pen_down, in_x_sample_*, in_y_sample_*
//   out      source     out_valid / out_stall out_screen_x/y, out_median_x/y, out_touch_valid
//   cfg      sink       cfg_we                cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_stall stays low. QW is clog2 of
// the larger screen extent and sets the quotient width of the one-bit-per-stage
// divider that follows the sort passes.
// A stage holds only when it and every stage after it are full while out_stall
// is high, so input is taken while a result waits until the whole pipe is full.
// Synchronous active-low reset clears the stage valids and loads the configuration
// registers with their defaults.
// ----------------------------------------------------------------------------
module touch_median_filter_calibrate #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_pen_down,
  input  logic [tmfc_pkg::RAW_W-1:0]          in_x_sample_0,
  input  logic [tmfc_pkg::RAW_W-1:0]          in_x_sample_1,
  input  logic [tmfc_pkg::RAW_W-1:0]          in_x_sample_2,
  input  logic [tmfc_pkg::RAW_W-1:0]          in_x_sample_3,
  input  logic [tmfc_pkg::RAW_W-1:0]          in_x_sample_4,
  input  logic [tmfc_pkg::RAW_W-1:0]          in_y_sample_0,
  input  logic [tmfc_pkg::RAW_W-1:0]          in_y_sample_1,
  input  logic [tmfc_pkg::RAW_W-1:0]          in_y_sample_2,
  input  logic [tmfc_pkg::RAW_W-1:0]          in_y_sample_3,
  input  logic [tmfc_pkg::RAW_W-1:0]          in_y_sample_4,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tmfc_pkg::SCREEN_OUT_W-1:0]   out_screen_x,
  output logic [tmfc_pkg::SCREEN_OUT_W-1:0]   out_screen_y,
  output logic [tmfc_pkg::RAW_W-1:0]          out_median_x,
  output logic [tmfc_pkg::RAW_W-1:0]          out_median_y,
  output logic                                out_touch_valid,
  // configuration
  input  logic                                cfg_we,
  input  logic [tmfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmfc_pkg::RAW_W-1:0]          cfg_wdata
);

  localparam int RAW_W   = tmfc_pkg::RAW_W;
  localparam int S       = tmfc_pkg::SAMPLES_PER_AXIS;
  localparam int EXT_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int QW      = $clog2(EXT_MAX);
  localparam int ML      = QW + 4;
  localparam int D       = S + 1 + ML;

  // configuration registers
  logic [RAW_W-1:0] cal_x_low_r, cal_x_high_r, cal_y_low_r, cal_y_high_r;
  logic [RAW_W-1:0] spread_limit_r;
  logic             swap_axes_r, mirror_x_r, mirror_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_x_low_r    <= '0;
      cal_x_high_r   <= tmfc_pkg::RAW_MAX;
      cal_y_low_r    <= '0;
      cal_y_high_r   <= tmfc_pkg::RAW_MAX;
      spread_limit_r <= RAW_W'(100);
      swap_axes_r    <= 1'b0;
      mirror_x_r     <= 1'b0;
      mirror_y_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tmfc_pkg::CFG_CAL_X_LOW:    cal_x_low_r    <= cfg_wdata;
        tmfc_pkg::CFG_CAL_X_HIGH:   cal_x_high_r   <= cfg_wdata;
        tmfc_pkg::CFG_CAL_Y_LOW:    cal_y_low_r    <= cfg_wdata;
        tmfc_pkg::CFG_CAL_Y_HIGH:   cal_y_high_r   <= cfg_wdata;
        tmfc_pkg::CFG_SPREAD_LIMIT: spread_limit_r <= cfg_wdata;
        tmfc_pkg::CFG_SWAP_AXES:    swap_axes_r    <= cfg_wdata[0];
        tmfc_pkg::CFG_MIRROR_X:     mirror_x_r     <= cfg_wdata[0];
        tmfc_pkg::CFG_MIRROR_Y:     mirror_y_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage advance: hold only on out_stall with this stage onward full
  logic [D-1:0] valid_r, valid_nxt, stage_en;

  for (genvar gi = 0; gi < D; gi++) begin : g_en
    assign stage_en[gi] = !((&valid_r[D-1:gi]) && out_stall);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (stage_en[0]) begin
      valid_nxt[0] = in_valid;
    end
    for (int i = 1; i < D; i++) begin
      if (stage_en[i]) begin
        valid_nxt[i] = valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !stage_en[0];
  assign out_valid = valid_r[D-1];

  // axis lanes
  tmfc_pkg::sample_vec_t x_vec, y_vec;
  tmfc_pkg::axis_res_t   x_res, y_res;

  assign x_vec = {in_x_sample_4, in_x_sample_3, in_x_sample_2, in_x_sample_1, in_x_sample_0};
  assign y_vec = {in_y_sample_4, in_y_sample_3, in_y_sample_2, in_y_sample_1, in_y_sample_0};

  tmfc_sort_lane u_lane_x (
    .clk          (clk),
    .en           (stage_en[S:0]),
    .samples      (x_vec),
    .spread_limit (spread_limit_r),
    .res          (x_res)
  );

  tmfc_sort_lane u_lane_y (
    .clk          (clk),
    .en           (stage_en[S:0]),
    .samples      (y_vec),
    .spread_limit (spread_limit_r),
    .res          (y_res)
  );

  // pen-down travels beside the sort lanes
  logic pen_r [S+1];

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      pen_r[0] <= in_pen_down;
    end
    for (int i = 1; i <= S; i++) begin
      if (stage_en[i]) begin
        pen_r[i] <= pen_r[i-1];
      end
    end
  end

  // merge: combine lane verdicts, pick the raw value for each screen axis
  logic [RAW_W-1:0]    raw_sx, raw_sy;
  tmfc_pkg::out_meta_t meta_nxt;
  tmfc_pkg::out_meta_t meta_r [ML];

  assign raw_sx = swap_axes_r ? y_res.median : x_res.median;
  assign raw_sy = swap_axes_r ? x_res.median : y_res.median;

  always_comb begin
    meta_nxt.median_x    = x_res.median;
    meta_nxt.median_y    = y_res.median;
    meta_nxt.touch_valid = pen_r[S] && x_res.ok && y_res.ok;
  end

  always_ff @(posedge clk) begin
    if (stage_en[S+1]) begin
      meta_r[0] <= meta_nxt;
    end
    for (int i = 1; i < ML; i++) begin
      if (stage_en[S+1+i]) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  // calibration lanes
  logic [tmfc_pkg::COORD_W-1:0] coord_x, coord_y;

  tmfc_map_lane #(
    .EXTENT (SCREEN_WIDTH),
    .QW     (QW)
  ) u_map_x (
    .clk      (clk),
    .en       (stage_en[D-1:S+1]),
    .raw      (raw_sx),
    .cal_low  (cal_x_low_r),
    .cal_high (cal_x_high_r),
    .mirror   (mirror_x_r),
    .coord    (coord_x)
  );

  tmfc_map_lane #(
    .EXTENT (SCREEN_HEIGHT),
    .QW     (QW)
  ) u_map_y (
    .clk      (clk),
    .en       (stage_en[D-1:S+1]),
    .raw      (raw_sy),
    .cal_low  (cal_y_low_r),
    .cal_high (cal_y_high_r),
    .mirror   (mirror_y_r),
    .coord    (coord_y)
  );

  // result fields
  assign out_screen_x    = coord_x[tmfc_pkg::SCREEN_OUT_W-1:0];
  assign out_screen_y    = coord_y[tmfc_pkg::SCREEN_OUT_W-1:0];
  assign out_median_x    = meta_r[ML-1].median_x;
  assign out_median_y    = meta_r[ML-1].median_y;
  assign out_touch_valid = meta_r[ML-1].touch_valid;

`ifndef SYNTHESIS
  // an accepted transaction always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> valid_r[0])
    else $error("accepted transaction lost at pipeline entry");

  // input only stalls when every stage is full and the output is held
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid_r) && out_stall)
    else $error("input stalled while the pipeline has a bubble");

  // a valid touch never carries a median on a rail
  a_valid_off_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_touch_valid |->
      out_median_x != '0 && out_median_x != tmfc_pkg::RAW_MAX &&
      out_median_y != '0 && out_median_y != tmfc_pkg::RAW_MAX)
    else $error("touch reported valid with a median on a rail");

  // screen column stays inside the screen
  a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> coord_x <= tmfc_pkg::COORD_W'(SCREEN_WIDTH - 1))
    else $error("screen column beyond screen width");

  // screen row stays inside the screen
  a_y_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> coord_y <= tmfc_pkg::COORD_W'(SCREEN_HEIGHT - 1))
    else $error("screen row beyond screen height");
`endif

endmodule

FILE: tb/sv/tmfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmfc_checker
// Watches the burst, result and register ports of the touch median filter.
// Every accepted burst gets a predicted result (median, spread and rail
// checks, swap, calibration, clamp, mirror), and every accepted result is
// compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tmfc_checker #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // burst channel
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_pen_down,
  input  tmfc_pkg::sample_vec_t               in_x,
  input  tmfc_pkg::sample_vec_t               in_y,
  // result channel
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [tmfc_pkg::SCREEN_OUT_W-1:0]   out_screen_x,
  input  logic [tmfc_pkg::SCREEN_OUT_W-1:0]   out_screen_y,
  input  logic [tmfc_pkg::RAW_W-1:0]          out_median_x,
  input  logic [tmfc_pkg::RAW_W-1:0]          out_median_y,
  input  logic                                out_touch_valid,
  // register writes
  input  logic                                cfg_we,
  input  logic [tmfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmfc_pkg::RAW_W-1:0]          cfg_wdata,
  // totals for the top
  output int                                  mismatches,
  output int                                  pending,
  output int                                  results_checked,
  output int                                  touches_accepted
);

  localparam int RAW_W            = tmfc_pkg::RAW_W;
  localparam int SCREEN_OUT_W     = tmfc_pkg::SCREEN_OUT_W;
  localparam int SAMPLES_PER_AXIS = tmfc_pkg::SAMPLES_PER_AXIS;
  localparam int MID_IDX          = tmfc_pkg::MID_IDX;
  localparam int QLO_IDX          = tmfc_pkg::QLO_IDX;
  localparam int QHI_IDX          = tmfc_pkg::QHI_IDX;
  localparam logic [RAW_W-1:0] RAW_MAX = tmfc_pkg::RAW_MAX;

  typedef struct packed {
    logic [SCREEN_OUT_W-1:0] screen_x;
    logic [SCREEN_OUT_W-1:0] screen_y;
    logic [RAW_W-1:0]        median_x;
    logic [RAW_W-1:0]        median_y;
    logic                    touch_valid;
  } touch_result_t;

  // shadow copy of the calibration registers
  logic [RAW_W-1:0] cal_x_low, cal_x_high, cal_y_low, cal_y_high, spread_limit;
  logic             swap_axes, mirror_x, mirror_y;

  touch_result_t expected_q[$];

  // ascending insertion sort of one axis
  function automatic tmfc_pkg::sample_vec_t sort_samples(tmfc_pkg::sample_vec_t v);
    logic [RAW_W-1:0] t;
    for (int i = 1; i < SAMPLES_PER_AXIS; i++) begin
      for (int j = i; j > 0; j--) begin
        if (v[j] < v[j-1]) begin
          t = v[j];
          v[j] = v[j-1];
          v[j-1] = t;
        end
      end
    end
    return v;
  endfunction

  // linear map onto 0..extent-1, truncating signed division, then clamp
  function automatic int scale_axis(int raw, int lo, int hi, int extent);
    int span;
    int v;
    span = hi - lo;
    if (span == 0) return 0;
    v = (raw - lo) * (extent - 1) / span;
    if (v < 0) v = 0;
    if (v >= extent) v = extent - 1;
    return v;
  endfunction

  function automatic touch_result_t predict_touch(logic pen, tmfc_pkg::sample_vec_t xv,
                                                  tmfc_pkg::sample_vec_t yv);
    tmfc_pkg::sample_vec_t xs, ys;
    touch_result_t         r;
    int                    sx, sy;
    xs = sort_samples(xv);
    ys = sort_samples(yv);
    r.median_x = xs[MID_IDX];
    r.median_y = ys[MID_IDX];
    // pen down, both quartile spreads in limit, neither median on a rail
    r.touch_valid = pen
      && (xs[QHI_IDX] - xs[QLO_IDX] <= spread_limit)
      && (ys[QHI_IDX] - ys[QLO_IDX] <= spread_limit)
      && (r.median_x != '0) && (r.median_x != RAW_MAX)
      && (r.median_y != '0) && (r.median_y != RAW_MAX);
    sx = scale_axis(swap_axes ? r.median_y : r.median_x, cal_x_low, cal_x_high,
                    SCREEN_WIDTH);
    sy = scale_axis(swap_axes ? r.median_x : r.median_y, cal_y_low, cal_y_high,
                    SCREEN_HEIGHT);
    if (mirror_x) sx = SCREEN_WIDTH - 1 - sx;
    if (mirror_y) sy = SCREEN_HEIGHT - 1 - sy;
    r.screen_x = sx[SCREEN_OUT_W-1:0];
    r.screen_y = sy[SCREEN_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    touch_result_t got;
    touch_result_t want;
    if (!rst_n) begin
      cal_x_low        = '0;
      cal_x_high       = RAW_MAX;
      cal_y_low        = '0;
      cal_y_high       = RAW_MAX;
      spread_limit     = 12'd100;
      swap_axes        = 1'b0;
      mirror_x         = 1'b0;
      mirror_y         = 1'b0;
      expected_q.delete();
      mismatches       = 0;
      pending          = 0;
      results_checked  = 0;
      touches_accepted = 0;
    end else begin
      // register writes, upper bits of the one-bit registers dropped
      if (cfg_we) begin
        case (cfg_index)
          tmfc_pkg::CFG_CAL_X_LOW:    cal_x_low = cfg_wdata;
          tmfc_pkg::CFG_CAL_X_HIGH:   cal_x_high = cfg_wdata;
          tmfc_pkg::CFG_CAL_Y_LOW:    cal_y_low = cfg_wdata;
          tmfc_pkg::CFG_CAL_Y_HIGH:   cal_y_high = cfg_wdata;
          tmfc_pkg::CFG_SPREAD_LIMIT: spread_limit = cfg_wdata;
          tmfc_pkg::CFG_SWAP_AXES:    swap_axes = cfg_wdata[0];
          tmfc_pkg::CFG_MIRROR_X:     mirror_x = cfg_wdata[0];
          tmfc_pkg::CFG_MIRROR_Y:     mirror_y = cfg_wdata[0];
          default: ;
        endcase
      end

      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{out_screen_x, out_screen_y, out_median_x, out_median_y,
                out_touch_valid};
        results_checked++;
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing expected: x=%0d y=%0d mx=%0d my=%0d ok=%0b",
                     $time, got.screen_x, got.screen_y, got.median_x, got.median_y,
                     got.touch_valid);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.touch_valid) touches_accepted++;
          if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
              got.median_x !== want.median_x || got.median_y !== want.median_y ||
              got.touch_valid !== want.touch_valid) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch exp x=%0d y=%0d mx=%0d my=%0d ok=%0b",
                       $time, want.screen_x, want.screen_y, want.median_x,
                       want.median_y, want.touch_valid);
              $display("%0t:          got x=%0d y=%0d mx=%0d my=%0d ok=%0b",
                       $time, got.screen_x, got.screen_y, got.median_x,
                       got.median_y, got.touch_valid);
            end
            mismatches++;
          end
        end
      end

      // burst transaction
      if (in_valid && !in_stall)
        expected_q.push_back(predict_touch(in_pen_down, in_x, in_y));

      pending = expected_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_touch_median_filter_calibrate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_median_filter_calibrate
// Drives touch bursts into the median filter and calibration block: a short
// directed set at reset values, then random clustered touches and noise
// across several calibration settings, with bursty input and a stalling
// result side. The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_touch_median_filter_calibrate;

  localparam int RAW_W              = tmfc_pkg::RAW_W;
  localparam int SCREEN_OUT_W       = tmfc_pkg::SCREEN_OUT_W;
  localparam int CFG_IDX_W          = tmfc_pkg::CFG_IDX_W;
  localparam int SAMPLES_PER_AXIS   = tmfc_pkg::SAMPLES_PER_AXIS;
  localparam int SCREEN_WIDTH       = 320;
  localparam int SCREEN_HEIGHT      = 480;
  localparam int CAL_SETTINGS       = 10;
  localparam int BURSTS_PER_SETTING = 175;
  localparam int DRAIN_CYCLES       = 30;
  localparam int IDLE_LIMIT         = 5000;

  typedef struct packed {
    logic                  pen_down;
    tmfc_pkg::sample_vec_t x;
    tmfc_pkg::sample_vec_t y;
  } touch_burst_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  touch_burst_t            burst = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [SCREEN_OUT_W-1:0] out_screen_x, out_screen_y;
  logic [RAW_W-1:0]        out_median_x, out_median_y;
  logic                    out_touch_valid;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = tmfc_pkg::CFG_CAL_X_LOW;
  logic [RAW_W-1:0]        cfg_wdata = '0;

  int mismatches, pending, results_checked, touches_accepted;
  int bursts_sent = 0;
  int settings_run = 0;
  int burst_left = 0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  touch_median_filter_calibrate #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pen_down    (burst.pen_down),
    .in_x_sample_0  (burst.x[0]),
    .in_x_sample_1  (burst.x[1]),
    .in_x_sample_2  (burst.x[2]),
    .in_x_sample_3  (burst.x[3]),
    .in_x_sample_4  (burst.x[4]),
    .in_y_sample_0  (burst.y[0]),
    .in_y_sample_1  (burst.y[1]),
    .in_y_sample_2  (burst.y[2]),
    .in_y_sample_3  (burst.y[3]),
    .in_y_sample_4  (burst.y[4]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_screen_x   (out_screen_x),
    .out_screen_y   (out_screen_y),
    .out_median_x   (out_median_x),
    .out_median_y   (out_median_y),
    .out_touch_valid(out_touch_valid),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  tmfc_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) touch_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pen_down     (burst.pen_down),
    .in_x            (burst.x),
    .in_y            (burst.y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_screen_x    (out_screen_x),
    .out_screen_y    (out_screen_y),
    .out_median_x    (out_median_x),
    .out_median_y    (out_median_y),
    .out_touch_valid (out_touch_valid),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .touches_accepted(touches_accepted)
  );

  // watchdog on cycles without any transaction
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results still due",
               IDLE_LIMIT, pending);
      $display("** touch_median_filter_calibrate: FAILED **");
      $finish;
    end
  end

  // result side stall, switching between patterns
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_mode_left = 0;
  int          stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 7;
    if (stall_mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_mode_left <= $urandom_range(20, 250);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_phase < 3);
    endcase
  end

  function automatic tmfc_pkg::sample_vec_t pack_samples(int s0, int s1, int s2, int s3,
                                                         int s4);
    tmfc_pkg::sample_vec_t v;
    v[0] = s0[RAW_W-1:0];
    v[1] = s1[RAW_W-1:0];
    v[2] = s2[RAW_W-1:0];
    v[3] = s3[RAW_W-1:0];
    v[4] = s4[RAW_W-1:0];
    return v;
  endfunction

  function automatic touch_burst_t make_burst(logic pen, tmfc_pkg::sample_vec_t xv,
                                              tmfc_pkg::sample_vec_t yv);
    touch_burst_t b;
    b.pen_down = pen;
    b.x = xv;
    b.y = yv;
    return b;
  endfunction

  // samples jittered around one point, with the odd wild outlier
  function automatic tmfc_pkg::sample_vec_t cluster_samples(int center, int jitter);
    tmfc_pkg::sample_vec_t v;
    int                    s;
    for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
      if ($urandom_range(0, 11) == 0)
        s = $urandom_range(0, 4095);
      else
        s = center + int'($urandom_range(0, 2 * jitter)) - jitter;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      v[i] = s[RAW_W-1:0];
    end
    return v;
  endfunction

  function automatic int pick_center();
    int rail_values[4] = '{0, 1, 4094, 4095};
    if ($urandom_range(0, 9) == 0) return rail_values[$urandom_range(0, 3)];
    return $urandom_range(0, 4095);
  endfunction

  function automatic touch_burst_t random_burst();
    touch_burst_t b;
    int           jit;
    if ($urandom_range(0, 9) < 7) begin
      // plausible touch: tight clusters, pen mostly down
      b.pen_down = ($urandom_range(0, 15) != 0);
      jit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 160) : $urandom_range(0, 40);
      b.x = cluster_samples(pick_center(), jit);
      b.y = cluster_samples(pick_center(), jit);
    end else begin
      // noise: any samples, any pen state
      b.pen_down = 1'($urandom_range(0, 1));
      for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
        b.x[i] = RAW_W'($urandom_range(0, 4095));
        b.y[i] = RAW_W'($urandom_range(0, 4095));
      end
    end
    return b;
  endfunction

  // present one burst and hold it until taken
  task automatic send_burst(touch_burst_t b);
    burst = b;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bursts_sent++;
    @(negedge clk);
  endtask

  // sender bursts with random gaps, now and then a long unbroken run
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAW_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // calibration setting per phase: fixed corner cases first, then random
  task automatic program_setting(int s);
    logic [RAW_W-1:0] xl, xh, yl, yh, lim, junk;
    logic             sw, mx, my;
    case (s)
      1: begin  // full span, widest spread limit
        xl = 0; xh = 4095; yl = 0; yh = 4095; lim = 4095;
        sw = 1'b0; mx = 1'b0; my = 1'b0;
      end
      2: begin  // equal bounds on both axes, zero spread limit
        xl = 2000; xh = 2000; yl = 0; yh = 0; lim = 0;
        sw = 1'b1; mx = 1'b1; my = 1'b1;
      end
      3: begin  // reversed bounds
        xl = 4095; xh = 0; yl = 3500; yh = 500; lim = 100;
        sw = 1'b0; mx = 1'b1; my = 1'b0;
      end
      4: begin  // narrow windows, most readings fall outside
        xl = 1000; xh = 1100; yl = 2000; yh = 2050; lim = 60;
        sw = 1'b1; mx = 1'b0; my = 1'b1;
      end
      default: begin
        xl = RAW_W'($urandom_range(0, 4095));
        xh = ($urandom_range(0, 7) == 0) ? xl : 12'($urandom_range(0, 4095));
        yl = RAW_W'($urandom_range(0, 4095));
        yh = ($urandom_range(0, 7) == 0) ? yl : 12'($urandom_range(0, 4095));
        case ($urandom_range(0, 3))
          0:       lim = 0;
          1:       lim = 4095;
          default: lim = RAW_W'($urandom_range(0, 300));
        endcase
        sw = 1'($urandom_range(0, 1));
        mx = 1'($urandom_range(0, 1));
        my = 1'($urandom_range(0, 1));
      end
    endcase
    write_reg(tmfc_pkg::CFG_CAL_X_LOW, xl);
    write_reg(tmfc_pkg::CFG_CAL_X_HIGH, xh);
    write_reg(tmfc_pkg::CFG_CAL_Y_LOW, yl);
    write_reg(tmfc_pkg::CFG_CAL_Y_HIGH, yh);
    write_reg(tmfc_pkg::CFG_SPREAD_LIMIT, lim);
    // junk in the unused upper bits must be ignored
    junk = RAW_W'($urandom);
    write_reg(tmfc_pkg::CFG_SWAP_AXES, {junk[RAW_W-1:1], sw});
    junk = RAW_W'($urandom);
    write_reg(tmfc_pkg::CFG_MIRROR_X, {junk[RAW_W-1:1], mx});
    junk = RAW_W'($urandom);
    write_reg(tmfc_pkg::CFG_MIRROR_Y, {junk[RAW_W-1:1], my});
  endtask

  // stimulus and verdict
  initial begin
    tmfc_pkg::sample_vec_t mid_y;
    mid_y = pack_samples(1500, 1510, 1495, 1505, 1500);
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed bursts at reset calibration
    send_burst(make_burst(1'b1, pack_samples(0, 0, 0, 0, 0), pack_samples(0, 0, 0, 0, 0)));
    send_burst(make_burst(1'b1, pack_samples(4095, 4095, 4095, 4095, 4095),
                          pack_samples(4095, 4095, 4095, 4095, 4095)));
    send_burst(make_burst(1'b1, pack_samples(2010, 1990, 2000, 2005, 1995), mid_y));
    send_burst(make_burst(1'b0, pack_samples(2010, 1990, 2000, 2005, 1995), mid_y));
    // quartile spread exactly at the limit, then one over on each axis
    send_burst(make_burst(1'b1, pack_samples(1000, 1100, 1050, 900, 1300), mid_y));
    send_burst(make_burst(1'b1, pack_samples(1000, 1101, 1050, 900, 1300), mid_y));
    send_burst(make_burst(1'b1, mid_y, pack_samples(1000, 1101, 1050, 900, 1300)));
    // medians one step off the rails
    send_burst(make_burst(1'b1, pack_samples(1, 1, 1, 0, 2),
                          pack_samples(4094, 4094, 4095, 4093, 4094)));
    // rail outliers that the median throws away, then a wide spread with no rails
    send_burst(make_burst(1'b1, pack_samples(0, 4095, 2048, 2050, 2046),
                          pack_samples(4095, 0, 3000, 3001, 2999)));
    send_burst(make_burst(1'b1, pack_samples(4000, 3000, 2000, 1000, 5),
                          pack_samples(5, 1000, 2000, 3000, 4000)));
    // alternating bit patterns
    send_burst(make_burst(1'b1, pack_samples(12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA),
                          pack_samples(12'h555, 12'h555, 12'h555, 12'h555, 12'h555)));
    send_burst(make_burst(1'b0, pack_samples(12'h555, 12'h555, 12'h555, 12'h555, 12'h555),
                          pack_samples(12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA)));
    // one axis median on a rail, then both medians near but off the rails
    send_burst(make_burst(1'b1, pack_samples(0, 0, 0, 5, 7), mid_y));
    send_burst(make_burst(1'b1, mid_y, pack_samples(4095, 4095, 4095, 4090, 4088)));
    send_burst(make_burst(1'b1, pack_samples(7, 7, 7, 7, 7),
                          pack_samples(4088, 4088, 4088, 4088, 4088)));

    // random bursts under each calibration setting
    for (int s = 0; s < CAL_SETTINGS; s++) begin
      if (s > 0) begin
        wait_idle();
        program_setting(s);
      end
      settings_run++;
      for (int n = 0; n < BURSTS_PER_SETTING; n++) begin
        pace_sender();
        send_burst(random_burst());
      end
    end
    wait_idle();

    $display("covered %0d bursts over %0d calibration settings", bursts_sent, settings_run);
    $display("checked %0d results, %0d of them valid touches, %0d mismatches",
             results_checked, touches_accepted, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("** touch_median_filter_calibrate: PASSED **");
    else
      $display("** touch_median_filter_calibrate: FAILED **");
    $finish;
  end

endmodule
